// File: hw/rtl/ssq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and constants of the servo sweep sequencer
// Command, phase and register codes, the configuration bundle and the
// request and response types of the serial multiply-divide unit.
// ----------------------------------------------------------------------------
package ssq_pkg;

    // Field widths of the stream payloads.
    localparam int CMD_W    = 2;
    localparam int TIME_W   = 32;
    localparam int REP_W    = 16;
    localparam int POS_W    = 8;
    localparam int PHASE_W  = 3;
    localparam int DUR_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    // Serial multiply-divide sizing: product of span and elapsed time, and a
    // quotient that only needs to be known up to one past the position range.
    localparam int PROD_W     = POS_W + TIME_W;
    localparam int QUOT_W     = POS_W + 1;
    localparam int MUL_STEPS  = POS_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

    // Sweep phase codes as presented on the output.
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RISE  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_MIDUP = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MAX   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FALL  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_MIDDN = 3'd5;
    localparam logic [PHASE_W-1:0] PH_MIN   = 3'd6;
    localparam logic [PHASE_W-1:0] PH_RSVD  = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MID_UP      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MID_DOWN    = 3'd7;

    // Configuration register bundle.
    typedef struct packed {
        logic [POS_W-1:0] min_angle;
        logic [POS_W-1:0] max_angle;
        logic [DUR_W-1:0] rise_ms;
        logic [DUR_W-1:0] fall_ms;
        logic [DUR_W-1:0] dwell_max_ms;
        logic [DUR_W-1:0] dwell_min_ms;
        logic [DUR_W-1:0] mid_pause_up_ms;
        logic [DUR_W-1:0] mid_pause_down_ms;
    } t_cfg;

    // Request to the multiply-divide unit.
    typedef struct packed {
        logic              start;
        logic [POS_W-1:0]  span;
        logic [TIME_W-1:0] elapsed;
        logic [DUR_W-1:0]  divisor;
    } t_md_req;

    // Response of the multiply-divide unit: a quotient past QUOT_W bits reads as 2^POS_W.
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_md_rsp;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_state;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EVAL,
        CTL_CALC,
        CTL_DONE
    } t_ctl_state;

endpackage

// File: hw/rtl/ssq_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_cfg: configuration register file
// Decodes the plain write port into the eight sweep settings.
// ----------------------------------------------------------------------------
module ssq_cfg import ssq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Write decode; the angle registers take the low byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MIN_ANGLE: r_cfg.min_angle         <= i_cfg_wdata[POS_W-1:0];
                REG_MAX_ANGLE: r_cfg.max_angle         <= i_cfg_wdata[POS_W-1:0];
                REG_RISE_MS:   r_cfg.rise_ms           <= i_cfg_wdata;
                REG_FALL_MS:   r_cfg.fall_ms           <= i_cfg_wdata;
                REG_DWELL_MAX: r_cfg.dwell_max_ms      <= i_cfg_wdata;
                REG_DWELL_MIN: r_cfg.dwell_min_ms      <= i_cfg_wdata;
                REG_MID_UP:    r_cfg.mid_pause_up_ms   <= i_cfg_wdata;
                REG_MID_DOWN:  r_cfg.mid_pause_down_ms <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/ssq_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_muldiv: bit-serial multiply and divide
// Forms span * elapsed one multiplier bit per cycle, then divides the product
// by the move time one quotient bit per cycle (restoring division). A quotient
// too wide for QUOT_W bits reads as 2^POS_W, which is all the position logic needs.
// ----------------------------------------------------------------------------
module ssq_muldiv import ssq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    t_md_state              r_state;
    t_md_state              n_state;
    logic [STEP_CNT_W-1:0]  r_cnt;
    logic [POS_W-1:0]       r_span;
    logic [TIME_W-1:0]      r_elapsed;
    logic [DUR_W-1:0]       r_div;
    logic [PROD_W-1:0]      r_prod;
    logic [DUR_W-1:0]       r_rem;
    logic [QUOT_W-1:0]      r_quot;
    logic                   r_ovf;
    logic                   r_done;

    logic                   w_mul_last;
    logic                   w_div_last;
    logic                   w_mul_en;
    logic                   w_div_en;
    logic [DUR_W:0]         w_trial;
    logic [DUR_W:0]         w_diff;
    logic                   w_ge;
    logic [PROD_W-1:0]      w_addend;

    assign w_mul_last = (r_cnt == STEP_CNT_W'(MUL_STEPS - 1));
    assign w_div_last = (r_cnt == STEP_CNT_W'(DIV_STEPS - 1));

    // Next state of the step sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            MD_IDLE: if (i_req.start) n_state = MD_MUL;
            MD_MUL:  if (w_mul_last) n_state = MD_DIV;
            MD_DIV:  if (w_div_last) n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    // Step enables decoded from the state.
    always_comb begin
        w_mul_en = 1'b0;
        w_div_en = 1'b0;
        case (r_state)
            MD_MUL:  w_mul_en = 1'b1;
            MD_DIV:  w_div_en = 1'b1;
            default: begin
            end
        endcase
    end

    // One multiply step: shift the product and add elapsed for a set bit.
    assign w_addend = r_span[POS_W-1] ? {{POS_W{1'b0}}, r_elapsed} : '0;

    // One divide step: bring down the next product bit and trial-subtract.
    assign w_trial = {r_rem, r_prod[PROD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_div_en && w_div_last;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge i_clk) begin
        if (r_state == MD_IDLE && i_req.start) begin
            r_span    <= i_req.span;
            r_elapsed <= i_req.elapsed;
            r_div     <= i_req.divisor;
            r_prod    <= '0;
            r_rem     <= '0;
            r_quot    <= '0;
            r_ovf     <= 1'b0;
            r_cnt     <= '0;
        end else if (w_mul_en) begin
            r_prod <= {r_prod[PROD_W-2:0], 1'b0} + w_addend;
            r_span <= {r_span[POS_W-2:0], 1'b0};
            r_cnt  <= w_mul_last ? '0 : r_cnt + 1'b1;
        end else if (w_div_en) begin
            r_rem  <= w_ge ? w_diff[DUR_W-1:0] : w_trial[DUR_W-1:0];
            r_prod <= {r_prod[PROD_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
            r_ovf  <= r_ovf | r_quot[QUOT_W-1];
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_ovf ? {1'b1, {(QUOT_W-1){1'b0}}} : r_quot;

endmodule

// File: hw/rtl/servo_sweep_sequencer.sv
`timescale 1ns / 1ps
// A rise or fall tick with a non-zero move time runs through the bit-serial
// multiply and then the divide before its result; every other item does not.
// One item is in flight at a time; the next input transfer is taken as soon as
// the previous result sits in the output register. Reset (synchronous, active
// low) clears all settings and state.
// ----------------------------------------------------------------------------
// servo_sweep_sequencer: oscillating servo sweep sequencer
// Steps a rise, pause, dwell, fall, pause, dwell cycle on ticks,
// interpolating positions with a serial multiply-divide unit.
// ----------------------------------------------------------------------------
module servo_sweep_sequencer import ssq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DAT_W-1:0]  i_cfg_wdata,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // now_ms, repeat_count, new_position
    input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // servo_position, phase, zero pad
    output logic [0:0]            m_axis_tuser   // position_written
);

    t_cfg        w_cfg;
    t_md_req     w_md_req;
    t_md_rsp     w_md_rsp;

    t_ctl_state  r_state;
    t_ctl_state  n_state;

    logic [CMD_W-1:0]   r_cmd;
    logic [TIME_W-1:0]  r_now;
    logic [REP_W-1:0]   r_rep_in;
    logic [POS_W-1:0]   r_new_pos;
    logic [TIME_W-1:0]  r_elapsed;
    logic [QUOT_W-1:0]  r_quot;

    logic [PHASE_W-1:0] r_phase;
    logic [POS_W-1:0]   r_cur_pos;
    logic [POS_W-1:0]   r_origin;
    logic [POS_W-1:0]   r_mid;
    logic [TIME_W-1:0]  r_phase_start;
    logic [REP_W-1:0]   r_repeats;

    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_pos;
    logic [PHASE_W-1:0] r_out_phase;
    logic               r_out_written;

    logic [PHASE_W-1:0] n_phase;
    logic [POS_W-1:0]   n_cur_pos;
    logic [POS_W-1:0]   n_origin;
    logic [POS_W-1:0]   n_mid;
    logic [TIME_W-1:0]  n_phase_start;
    logic [REP_W-1:0]   n_repeats;
    logic               n_written;

    logic               w_accept;
    logic               w_need_div;
    logic               w_commit;
    logic               w_ready;
    logic               w_md_start;
    logic [POS_W-1:0]   w_span;

    ssq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Span is zero when the limits are inverted.
    assign w_span = (w_cfg.max_angle >= w_cfg.min_angle) ?
                    (w_cfg.max_angle - w_cfg.min_angle) : '0;

    // A divide is needed for a rise or fall tick with a non-zero move time.
    assign w_need_div = (r_cmd == CMD_TICK) &&
                        (((r_phase == PH_RISE) && (w_cfg.rise_ms != '0)) ||
                         ((r_phase == PH_FALL) && (w_cfg.fall_ms != '0)));

    assign w_md_req.start   = w_md_start;
    assign w_md_req.span    = w_span;
    assign w_md_req.elapsed = r_elapsed;
    assign w_md_req.divisor = (r_phase == PH_RISE) ? w_cfg.rise_ms : w_cfg.fall_ms;

    ssq_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_rsp   (w_md_rsp)
    );

    // Control sequencer: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            CTL_IDLE: if (w_accept) n_state = CTL_EVAL;
            CTL_EVAL: n_state = w_need_div ? CTL_CALC : CTL_DONE;
            CTL_CALC: if (w_md_rsp.done) n_state = CTL_DONE;
            CTL_DONE: if (w_commit) n_state = CTL_IDLE;
            default:  n_state = CTL_IDLE;
        endcase
    end

    // Control sequencer: outputs.
    always_comb begin
        w_ready    = 1'b0;
        w_md_start = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            CTL_IDLE: w_ready    = 1'b1;
            CTL_EVAL: w_md_start = w_need_div;
            CTL_DONE: w_commit   = !r_out_valid || m_axis_tready;
            default: begin
            end
        endcase
    end

    assign s_axis_tready = w_ready;
    assign w_accept      = s_axis_tvalid && w_ready;

    // Sweep update applied when the item completes.
    always_comb begin
        logic [POS_W+1:0] v_sum;
        logic [POS_W-1:0] v_pos;
        logic [DUR_W:0]   v_max_wait;
        logic [REP_W-1:0] v_rep;

        n_phase       = r_phase;
        n_cur_pos     = r_cur_pos;
        n_origin      = r_origin;
        n_mid         = r_mid;
        n_phase_start = r_phase_start;
        n_repeats     = r_repeats;
        n_written     = 1'b0;
        v_sum         = {2'b00, r_origin} + {1'b0, r_quot};
        v_pos         = r_cur_pos;
        v_max_wait    = {1'b0, w_cfg.rise_ms} + {1'b0, w_cfg.dwell_max_ms};
        v_rep         = r_repeats - 1'b1;

        case (r_cmd)
            CMD_TICK: begin
                case (r_phase)
                    PH_RISE: begin
                        n_written = 1'b1;
                        if (w_cfg.rise_ms == '0) begin
                            v_pos = w_cfg.max_angle;
                        end else if (v_sum > {2'b00, w_cfg.max_angle}) begin
                            v_pos = w_cfg.max_angle;
                        end else begin
                            v_pos = v_sum[POS_W-1:0];
                        end
                        if (v_pos < r_cur_pos) v_pos = r_cur_pos;
                        // Stop at the middle point on the way up.
                        if (r_cur_pos < r_mid && v_pos >= r_mid) begin
                            v_pos         = r_mid;
                            n_phase       = PH_MIDUP;
                            n_phase_start = r_now;
                        end
                        n_cur_pos = v_pos;
                        if (v_pos >= w_cfg.max_angle) n_phase = PH_MAX;
                    end
                    PH_MIDUP: begin
                        if (r_elapsed > {16'd0, w_cfg.mid_pause_up_ms}) begin
                            n_phase_start = r_phase_start + {16'd0, w_cfg.mid_pause_up_ms};
                            n_phase       = PH_RISE;
                        end
                    end
                    PH_MAX: begin
                        if (r_elapsed >= {15'd0, v_max_wait}) begin
                            n_phase       = PH_FALL;
                            n_phase_start = r_now;
                        end
                    end
                    PH_FALL: begin
                        n_written = 1'b1;
                        if (w_cfg.fall_ms == '0) begin
                            v_pos = w_cfg.min_angle;
                        end else begin
                            // Travel beyond the upper limit saturates at zero.
                            v_pos = (r_quot >= {1'b0, w_cfg.max_angle}) ? '0 :
                                    (w_cfg.max_angle - r_quot[POS_W-1:0]);
                            if (v_pos < w_cfg.min_angle) v_pos = w_cfg.min_angle;
                        end
                        if (v_pos > r_cur_pos) v_pos = r_cur_pos;
                        // Stop at the middle point on the way down.
                        if (r_cur_pos > r_mid && v_pos <= r_mid) begin
                            v_pos         = r_mid;
                            n_phase       = PH_MIDDN;
                            n_phase_start = r_now;
                        end
                        n_cur_pos = v_pos;
                        if (v_pos <= w_cfg.min_angle) begin
                            n_cur_pos = w_cfg.min_angle;
                            n_phase   = PH_MIN;
                        end
                    end
                    PH_MIDDN: begin
                        if (r_elapsed >= {16'd0, w_cfg.mid_pause_down_ms}) begin
                            n_phase_start = r_phase_start + {16'd0, w_cfg.mid_pause_down_ms};
                            n_phase       = PH_FALL;
                        end
                    end
                    PH_MIN: begin
                        // One repetition ends here.
                        if (r_elapsed >= {16'd0, w_cfg.dwell_min_ms}) begin
                            n_phase_start = r_now;
                            n_origin      = w_cfg.min_angle;
                            n_repeats     = v_rep;
                            n_phase       = (v_rep == '0) ? PH_IDLE : PH_RISE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            CMD_START: begin
                n_origin      = r_cur_pos;
                n_mid         = r_cur_pos;
                n_phase       = PH_RISE;
                n_repeats     = r_rep_in;
                n_phase_start = r_now;
            end
            CMD_SET: begin
                n_cur_pos = r_new_pos;
                n_written = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control and sweep state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= CTL_IDLE;
            r_phase       <= PH_IDLE;
            r_cur_pos     <= '0;
            r_origin      <= '0;
            r_mid         <= '0;
            r_phase_start <= '0;
            r_repeats     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_phase       <= n_phase;
                r_cur_pos     <= n_cur_pos;
                r_origin      <= n_origin;
                r_mid         <= n_mid;
                r_phase_start <= n_phase_start;
                r_repeats     <= n_repeats;
                r_out_valid   <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // Item capture, quotient capture and result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= s_axis_tuser;
            r_now     <= s_axis_tdata[TIME_W-1:0];
            r_rep_in  <= s_axis_tdata[TIME_W+REP_W-1:TIME_W];
            r_new_pos <= s_axis_tdata[TIME_W+REP_W+POS_W-1:TIME_W+REP_W];
            r_elapsed <= s_axis_tdata[TIME_W-1:0] - r_phase_start;
        end
        if (w_md_rsp.done) begin
            r_quot <= w_md_rsp.quot;
        end
        if (w_commit) begin
            r_out_pos     <= n_cur_pos;
            r_out_phase   <= n_phase;
            r_out_written <= n_written;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-POS_W-PHASE_W){1'b0}}, r_out_phase, r_out_pos};
    assign m_axis_tuser  = r_out_written;

    // The divide unit only answers while the sequencer waits for it.
    a_md_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_rsp.done |-> (r_state == CTL_CALC))
        else $error("divide result outside the calculation state");

    // The unused phase code is never reached.
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_RSVD)
        else $error("phase register holds the reserved code");

    // A rising tick never moves the servo down.
    a_rise_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_cmd == CMD_TICK && r_phase == PH_RISE)
        |=> (r_cur_pos >= $past(r_cur_pos)))
        else $error("position fell during a rise");

    // A falling tick never moves the servo up, unless a position below the
    // lower limit is pulled up to that limit.
    a_fall_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_cmd == CMD_TICK && r_phase == PH_FALL)
        |=> (r_cur_pos <= $past(r_cur_pos) || r_cur_pos == w_cfg.min_angle))
        else $error("position rose during a fall");

endmodule

// File: bench/servo_sweep_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_sweep_checker: result checker for the servo sweep sequencer
// Watches the settings port and both stream channels. It keeps its own copy
// of the sweep settings and state, works out the result of every accepted
// input transfer and compares each output transfer field by field against
// the oldest result still owed.
// ----------------------------------------------------------------------------
module servo_sweep_checker import ssq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DAT_W-1:0]  i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // now_ms, repeat_count, new_position
    input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // servo_position, phase, zero pad
    input  logic [0:0]            m_axis_tuser,  // position_written
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic               written;
        logic [PHASE_W-1:0] phase;
    } t_servo_update;

    // Sweep settings as last written.
    logic [POS_W-1:0] lim_lo, lim_hi;
    logic [DUR_W-1:0] dur_rise, dur_fall, dur_hold_hi, dur_hold_lo;
    logic [DUR_W-1:0] dur_pause_up, dur_pause_dn;

    // Sweep state.
    logic [PHASE_W-1:0] sweep_phase;
    logic [POS_W-1:0]   pos_now, climb_origin, mid_point;
    logic [TIME_W-1:0]  phase_t0;
    logic [REP_W-1:0]   sweeps_left;

    t_servo_update servo_updates_q[$];
    t_servo_update owed;
    int            mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // One line per mismatch.
    task automatic report(input string msg);
        $display("[%0t] servo check: %s", $time, msg);
        mismatch_count++;
    endtask

    // Applies one input item to the sweep state and returns the result it gives.
    function automatic t_servo_update step_sweep(input logic [CMD_W-1:0] cmd,
                                                 input logic [TIME_W-1:0] now,
                                                 input logic [REP_W-1:0] reps,
                                                 input logic [POS_W-1:0] new_pos);
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       span, target, travelled;
        logic              drove;
        t_servo_update     upd;
        drove   = 1'b0;
        elapsed = now - phase_t0;
        // Inverted limits leave nothing to travel.
        span = 64'd0;
        if (lim_hi >= lim_lo)
            span = lim_hi - lim_lo;
        case (cmd)
            CMD_TICK: begin
                case (sweep_phase)
                    PH_RISE: begin
                        if (dur_rise == '0) begin
                            target = lim_hi;
                        end else begin
                            target = climb_origin + (span * elapsed) / dur_rise;
                            if (target > lim_hi)
                                target = lim_hi;
                        end
                        // Never move backwards; stop at the middle on the way up.
                        if (target < pos_now)
                            target = pos_now;
                        if (pos_now < mid_point && target >= mid_point) begin
                            target      = mid_point;
                            sweep_phase = PH_MIDUP;
                            phase_t0    = now;
                        end
                        pos_now = target[POS_W-1:0];
                        if (pos_now >= lim_hi)
                            sweep_phase = PH_MAX;
                        drove = 1'b1;
                    end
                    PH_MIDUP: begin
                        if (elapsed > dur_pause_up) begin
                            phase_t0    = phase_t0 + dur_pause_up;
                            sweep_phase = PH_RISE;
                        end
                    end
                    PH_MAX: begin
                        // The dwell at the top is counted on top of the rise time.
                        if (64'(elapsed) >= 64'(dur_rise) + 64'(dur_hold_hi)) begin
                            sweep_phase = PH_FALL;
                            phase_t0    = now;
                        end
                    end
                    PH_FALL: begin
                        if (dur_fall == '0) begin
                            target = lim_lo;
                        end else begin
                            // The fall saturates at zero before the lower clamp.
                            travelled = (span * elapsed) / dur_fall;
                            target    = (travelled >= lim_hi) ? 64'd0 : lim_hi - travelled;
                            if (target < lim_lo)
                                target = lim_lo;
                        end
                        if (target > pos_now)
                            target = pos_now;
                        if (pos_now > mid_point && target <= mid_point) begin
                            target      = mid_point;
                            sweep_phase = PH_MIDDN;
                            phase_t0    = now;
                        end
                        pos_now = target[POS_W-1:0];
                        if (pos_now <= lim_lo) begin
                            pos_now     = lim_lo;
                            sweep_phase = PH_MIN;
                        end
                        drove = 1'b1;
                    end
                    PH_MIDDN: begin
                        if (elapsed >= dur_pause_dn) begin
                            phase_t0    = phase_t0 + dur_pause_dn;
                            sweep_phase = PH_FALL;
                        end
                    end
                    PH_MIN: begin
                        // End of one repetition; a zero count wraps and carries on.
                        if (elapsed >= dur_hold_lo) begin
                            sweep_phase  = PH_RISE;
                            phase_t0     = now;
                            climb_origin = lim_lo;
                            sweeps_left  = sweeps_left - 1'b1;
                            if (sweeps_left == '0)
                                sweep_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        sweep_phase = PH_IDLE;
                    end
                endcase
            end
            CMD_START: begin
                climb_origin = pos_now;
                mid_point    = pos_now;
                sweep_phase  = PH_RISE;
                sweeps_left  = reps;
                phase_t0     = now;
            end
            CMD_SET: begin
                pos_now = new_pos;
                drove   = 1'b1;
            end
            default: begin
            end
        endcase
        upd.position = pos_now;
        upd.written  = drove;
        upd.phase    = sweep_phase;
        return upd;
    endfunction

    // Settings writes, result checks and predictions, in that order per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_lo       = '0;
            lim_hi       = '0;
            dur_rise     = '0;
            dur_fall     = '0;
            dur_hold_hi  = '0;
            dur_hold_lo  = '0;
            dur_pause_up = '0;
            dur_pause_dn = '0;
            sweep_phase  = PH_IDLE;
            pos_now      = '0;
            climb_origin = '0;
            mid_point    = '0;
            phase_t0     = '0;
            sweeps_left  = '0;
            servo_updates_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MIN_ANGLE: lim_lo       = i_cfg_wdata[POS_W-1:0];
                    REG_MAX_ANGLE: lim_hi       = i_cfg_wdata[POS_W-1:0];
                    REG_RISE_MS:   dur_rise     = i_cfg_wdata;
                    REG_FALL_MS:   dur_fall     = i_cfg_wdata;
                    REG_DWELL_MAX: dur_hold_hi  = i_cfg_wdata;
                    REG_DWELL_MIN: dur_hold_lo  = i_cfg_wdata;
                    REG_MID_UP:    dur_pause_up = i_cfg_wdata;
                    REG_MID_DOWN:  dur_pause_dn = i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (servo_updates_q.size() == 0) begin
                    report($sformatf("result transfer with nothing owed (data %h)",
                                     m_axis_tdata));
                end else begin
                    owed = servo_updates_q.pop_front();
                    if (m_axis_tdata[POS_W-1:0] !== owed.position)
                        report($sformatf("servo_position %0d, expected %0d",
                                         m_axis_tdata[POS_W-1:0], owed.position));
                    if (m_axis_tuser[0] !== owed.written)
                        report($sformatf("position_written %b, expected %b",
                                         m_axis_tuser[0], owed.written));
                    if (m_axis_tdata[POS_W +: PHASE_W] !== owed.phase)
                        report($sformatf("phase %0d, expected %0d",
                                         m_axis_tdata[POS_W +: PHASE_W], owed.phase));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                servo_updates_q.push_back(step_sweep(s_axis_tuser,
                                                     s_axis_tdata[TIME_W-1:0],
                                                     s_axis_tdata[TIME_W +: REP_W],
                                                     s_axis_tdata[TIME_W+REP_W +: POS_W]));
            o_pending <= servo_updates_q.size();
        end
    end

endmodule

// File: bench/tb_servo_sweep_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_sweep_sequencer: stimulus and verdict for the servo sweep sequencer
// A directed opening walks one full sweep across the wrap of the millisecond
// counter, then nine phases of settings (zero times, inverted limits, the
// longest times and random values) each drive mostly well-formed sweeps with
// ticks, restarts and position writes. Both channels idle at random except
// in the last phase; the checker module does all the comparing.
// ----------------------------------------------------------------------------
module tb_servo_sweep_sequencer;
    import ssq_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SWEEP_SETS   = 9;
    localparam int SET_ITEMS    = 200;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = REG_MIN_ANGLE;
    logic [CFG_DAT_W-1:0]  i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // now_ms, repeat_count, new_position
    logic [CMD_W-1:0]      s_axis_tuser  = CMD_TICK;  // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;  // servo_position, phase, zero pad
    logic [0:0]            m_axis_tuser;  // position_written

    int                 mismatches;
    int                 pending;
    int                 cycle_count;
    int                 stall_left   = 0;
    int                 step_max     = 1;
    int                 pick;
    int                 lo_pick;
    logic               calm         = 1'b0;
    logic [PHASE_W-1:0] seen_phase   = PH_IDLE;
    logic [TIME_W-1:0]  clock_ms     = '0;
    logic [REP_W-1:0]   sweep_reps;

    servo_sweep_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    servo_sweep_checker sweep_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // 2 ns clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Receiver stalls in random bursts, none once the run is calm.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Last phase seen on the output, used to restart sweeps that have ended.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            seen_phase <= m_axis_tdata[POS_W +: PHASE_W];
    end

    // Offers one item and returns at the edge where its transfer happens.
    task automatic send(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
                        input logic [REP_W-1:0] reps, input logic [POS_W-1:0] new_pos);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {new_pos, reps, now};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // A tick some random milliseconds on, with junk in the unused fields.
    task automatic tick();
        clock_ms = clock_ms + $urandom_range(0, step_max);
        send(CMD_TICK, clock_ms, REP_W'($urandom_range(0, 16'hFFFF)),
             POS_W'($urandom_range(0, 8'hFF)));
    endtask

    // Holds the sender back until every result owed has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
    endtask

    task automatic program_regs(input logic [CFG_DAT_W-1:0] lo, input logic [CFG_DAT_W-1:0] hi,
                                input logic [CFG_DAT_W-1:0] rise, input logic [CFG_DAT_W-1:0] fall,
                                input logic [CFG_DAT_W-1:0] hold_hi,
                                input logic [CFG_DAT_W-1:0] hold_lo,
                                input logic [CFG_DAT_W-1:0] pause_up,
                                input logic [CFG_DAT_W-1:0] pause_dn);
        put_reg(REG_MIN_ANGLE, lo);
        put_reg(REG_MAX_ANGLE, hi);
        put_reg(REG_RISE_MS, rise);
        put_reg(REG_FALL_MS, fall);
        put_reg(REG_DWELL_MAX, hold_hi);
        put_reg(REG_DWELL_MIN, hold_lo);
        put_reg(REG_MID_UP, pause_up);
        put_reg(REG_MID_DOWN, pause_dn);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Run limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("servo_sweep_sequencer: mismatch");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: idle commands, the reserved code, position extremes,
        // then one full sweep that crosses the wrap of the millisecond counter.
        program_regs(10, 200, 20, 20, 5, 5, 3, 3);
        clock_ms = 32'hFFFF_FFF0;
        send(CMD_TICK, clock_ms, '0, '0);
        send(CMD_RSVD, '1, '1, '1);
        send(CMD_SET, clock_ms, '0, 8'hFF);
        send(CMD_SET, clock_ms, '0, 8'h00);
        send(CMD_SET, clock_ms, '0, 8'd100);
        send(CMD_START, clock_ms, 16'd1, '0);
        repeat (16) begin
            clock_ms = clock_ms + 32'd5;
            send(CMD_TICK, clock_ms, '0, '0);
        end
        // A zero repetition count wraps round and keeps sweeping.
        send(CMD_START, clock_ms, 16'd0, '0);
        tick();

        // Random sweeps under changing settings; each change waits for the
        // block to fall quiet.
        for (int set_no = 0; set_no < SWEEP_SETS; set_no++) begin
            drain();
            case (set_no)
                0: begin
                    // Zero move and dwell times, full range of positions.
                    program_regs(16'hFF00, 16'hFFFF, 0, 0, 0, 0, 0, 0);
                    step_max = 3;
                end
                1: begin
                    // Upper limit below the lower one.
                    program_regs(200, 50, 10, 10, 4, 4, 2, 2);
                    step_max = 3;
                end
                2: begin
                    // Longest times, with big jumps of the clock.
                    program_regs(0, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF);
                    step_max = 40000;
                end
                default: begin
                    lo_pick = $urandom_range(0, 120);
                    program_regs(CFG_DAT_W'(lo_pick + 256 * $urandom_range(0, 255)),
                                 CFG_DAT_W'($urandom_range(100, 255) +
                                            256 * $urandom_range(0, 255)),
                                 CFG_DAT_W'($urandom_range(0, 60)),
                                 CFG_DAT_W'($urandom_range(0, 60)),
                                 CFG_DAT_W'($urandom_range(0, 30)),
                                 CFG_DAT_W'($urandom_range(0, 30)),
                                 CFG_DAT_W'($urandom_range(0, 8)),
                                 CFG_DAT_W'($urandom_range(0, 8)));
                    step_max = $urandom_range(1, 6);
                end
            endcase
            calm = (set_no == SWEEP_SETS - 1);
            repeat (SET_ITEMS) begin
                pick = $urandom_range(0, 99);
                if ((seen_phase == PH_IDLE && pick < 30) || pick == 99) begin
                    // Restart: mostly a few repetitions, now and then zero or many.
                    case ($urandom_range(0, 9))
                        0:       sweep_reps = '0;
                        1:       sweep_reps = REP_W'($urandom_range(0, 16'hFFFF));
                        default: sweep_reps = REP_W'($urandom_range(1, 3));
                    endcase
                    send(CMD_START, clock_ms, sweep_reps, POS_W'($urandom_range(0, 8'hFF)));
                end else if (pick < 34) begin
                    send(CMD_SET, clock_ms, REP_W'($urandom_range(0, 16'hFFFF)),
                         POS_W'($urandom_range(0, 8'hFF)));
                end else if (pick < 36) begin
                    send(CMD_RSVD, $urandom, REP_W'($urandom_range(0, 16'hFFFF)),
                         POS_W'($urandom_range(0, 8'hFF)));
                end else if (pick == 36) begin
                    // Clock jump: long elapsed times and fall underflow.
                    clock_ms = $urandom;
                    tick();
                end else begin
                    tick();
                end
            end
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("servo_sweep_sequencer: match");
        else
            $display("servo_sweep_sequencer: mismatch");
        $finish;
    end

endmodule
